@@ hw/rtl/arcb_pkg.sv @@
// Shared constants, types and register indexes of the arcball rotation tracker.
package arcb_pkg;

    localparam int COORD_BITS = 12;
    localparam int FRAC_BITS  = 30;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;
    localparam int EPS_W      = 31;
    localparam int VEC_W      = 32;
    localparam int MUL_W      = 34;
    localparam int ACC_W      = 2 * MUL_W;

    localparam int DIV_NUM_W  = 96;
    localparam int DIV_DEN_W  = 64;
    localparam int DIV_STEPS  = DIV_NUM_W;
    localparam int SQRT_STEPS = DIV_DEN_W / 2;
    localparam int CNT_W      = $clog2(DIV_STEPS);

    localparam logic [CFG_IDX_W-1:0] CFG_X_SCALE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_Y_SCALE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_EPS     = 2'd2;

    typedef logic signed [MUL_W-1:0] mul_t;
    typedef logic signed [ACC_W-1:0] acc_t;
    typedef logic signed [VEC_W-1:0] vec_t;

    localparam acc_t ONE_A   = acc_t'(1) <<< FRAC_BITS;
    localparam acc_t TWO_A   = acc_t'(1) <<< (FRAC_BITS + 1);
    localparam acc_t I32_MAX = (acc_t'(1) <<< 31) - acc_t'(1);
    localparam acc_t I32_MIN = -(acc_t'(1) <<< 31);
    localparam logic [DIV_DEN_W-1:0] UNIT2 = DIV_DEN_W'(1) << (2 * FRAC_BITS);
    localparam logic [DIV_NUM_W-1:0] SQRT_BIT0 = DIV_NUM_W'(1) << (2 * SQRT_STEPS - 2);

    localparam logic [CFG_DATA_W-1:0] SCALE_RESET = 32'h8000_0000;
    localparam logic [EPS_W-1:0]      EPS_RESET   = 31'd1;

    typedef struct packed {
        logic start;
        logic sqrt_mode;
    } arcb_cmd_t;

    typedef struct packed {
        logic done;
    } arcb_stat_t;

endpackage

@@ hw/rtl/arcb_if.sv @@
// Pointer event and matrix result channels.
interface arcb_evt_if;
    logic                            valid;
    logic                            ready;
    logic                            func;
    logic [arcb_pkg::COORD_BITS-1:0] pos_x;
    logic [arcb_pkg::COORD_BITS-1:0] pos_y;

    modport source (output valid, func, pos_x, pos_y, input ready);
    modport sink (input valid, func, pos_x, pos_y, output ready);
endinterface

interface arcb_mat_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] m00;
    logic signed [31:0] m01;
    logic signed [31:0] m02;
    logic signed [31:0] m10;
    logic signed [31:0] m11;
    logic signed [31:0] m12;
    logic signed [31:0] m20;
    logic signed [31:0] m21;
    logic signed [31:0] m22;

    modport source (output valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
                    input ready);
    modport sink (input valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
                  output ready);
endinterface

@@ hw/rtl/arcb_divsqrt.sv @@
// Iterative restoring divider and integer square root on one compare-subtract.
module arcb_divsqrt (
    input  logic                                clk,
    input  logic                                rst_n,
    input  arcb_pkg::arcb_cmd_t                 cmd,
    input  logic [arcb_pkg::DIV_NUM_W-1:0]      num,
    input  logic [arcb_pkg::DIV_DEN_W-1:0]      den,
    output arcb_pkg::arcb_stat_t                stat,
    output logic [arcb_pkg::DIV_DEN_W-1:0]      res
);

    logic                               busy_reg;
    logic                               mode_reg;
    logic                               done_reg;
    logic [arcb_pkg::CNT_W-1:0]         cnt_reg;
    logic [arcb_pkg::DIV_DEN_W-1:0]     a_reg;
    logic [arcb_pkg::DIV_DEN_W-1:0]     q_reg;
    logic [arcb_pkg::DIV_DEN_W-1:0]     d_reg;
    logic [arcb_pkg::DIV_NUM_W-1:0]     b_reg;
    logic [arcb_pkg::DIV_DEN_W:0]       cs_x;
    logic [arcb_pkg::DIV_DEN_W:0]       cs_y;
    logic [arcb_pkg::DIV_DEN_W:0]       cs_diff;
    logic                               cs_ge;
    logic                               last;

    // sqrt: v >= res + bit; divide: partial remainder with next numerator bit >= divisor
    always_comb
    begin
        if (mode_reg)
        begin
            cs_x = {1'b0, a_reg};
            cs_y = {1'b0, q_reg + b_reg[arcb_pkg::DIV_DEN_W-1:0]};
        end
        else
        begin
            cs_x = {a_reg, b_reg[arcb_pkg::DIV_NUM_W-1]};
            cs_y = {1'b0, d_reg};
        end
        cs_ge   = cs_x >= cs_y;
        cs_diff = cs_x - cs_y;
        last    = mode_reg ? (cnt_reg == arcb_pkg::CNT_W'(arcb_pkg::SQRT_STEPS - 1))
                           : (cnt_reg == arcb_pkg::CNT_W'(arcb_pkg::DIV_STEPS - 1));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            mode_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (cmd.start)
            begin
                busy_reg <= 1'b1;
                mode_reg <= cmd.sqrt_mode;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (last)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            q_reg <= '0;
            d_reg <= den;
            if (cmd.sqrt_mode)
            begin
                a_reg <= num[arcb_pkg::DIV_DEN_W-1:0];
                b_reg <= arcb_pkg::SQRT_BIT0;
            end
            else
            begin
                a_reg <= '0;
                b_reg <= num;
            end
        end
        else if (busy_reg)
        begin
            if (mode_reg)
            begin
                if (cs_ge)
                begin
                    a_reg <= cs_diff[arcb_pkg::DIV_DEN_W-1:0];
                    q_reg <= (q_reg >> 1) + b_reg[arcb_pkg::DIV_DEN_W-1:0];
                end
                else
                begin
                    q_reg <= q_reg >> 1;
                end
                b_reg <= b_reg >> 2;
            end
            else
            begin
                if (cs_ge)
                begin
                    a_reg <= cs_diff[arcb_pkg::DIV_DEN_W-1:0];
                    q_reg <= {q_reg[arcb_pkg::DIV_DEN_W-2:0], 1'b1};
                end
                else
                begin
                    a_reg <= cs_x[arcb_pkg::DIV_DEN_W-1:0];
                    q_reg <= {q_reg[arcb_pkg::DIV_DEN_W-2:0], 1'b0};
                end
                b_reg <= b_reg << 1;
            end
        end
    end

    assign stat.done = done_reg;
    assign res       = q_reg;

    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.start |-> !busy_reg)
        else $error("divsqrt started while busy");

    a_sqrt_count: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg && mode_reg |-> cnt_reg < arcb_pkg::CNT_W'(arcb_pkg::SQRT_STEPS))
        else $error("sqrt ran past its step count");

    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        stat.done |-> $past(busy_reg))
        else $error("done without a running operation");

endmodule

@@ hw/rtl/arcball_rotation_tracker.sv @@
// Arcball rotation tracker: pointer events in, current 3x3 rotation matrix out.
// One event at a time: ready is high only while the sequencer is idle, and one
// matrix beat leaves per event through an output register, so the next event is
// taken while the last matrix still waits. All math runs on one 34x34 multiply-
// accumulate and one iterative divide/sqrt unit (96 steps per divide, 32 per
// root). A start takes one root, plus two divides outside the unit disc. A drag
// adds multiply-accumulate work plus nine divides; a drag whose cross product
// falls under the threshold skips the divides.
module arcball_rotation_tracker (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [arcb_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [arcb_pkg::CFG_DATA_W-1:0]      cfg_data,
    arcb_evt_if.sink                             evt,
    arcb_mat_if.source                           mat
);

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_MAP   = 4'd1;
    localparam logic [3:0] ST_SQ    = 4'd2;
    localparam logic [3:0] ST_ROOT  = 4'd3;
    localparam logic [3:0] ST_NRM   = 4'd4;
    localparam logic [3:0] ST_SPH   = 4'd5;
    localparam logic [3:0] ST_CROSS = 4'd6;
    localparam logic [3:0] ST_DOT   = 4'd7;
    localparam logic [3:0] ST_LEN   = 4'd8;
    localparam logic [3:0] ST_NORM  = 4'd9;
    localparam logic [3:0] ST_RNUM  = 4'd10;
    localparam logic [3:0] ST_RDIV  = 4'd11;
    localparam logic [3:0] ST_PROD  = 4'd12;
    localparam logic [3:0] ST_OUT   = 4'd13;

    logic [3:0]   state_reg;
    logic         ph_reg;
    logic [2:0]   idx_reg;
    logic [3:0]   el_reg;
    logic [1:0]   row_reg;
    logic [1:0]   col_reg;
    logic         ov_reg;

    logic [arcb_pkg::CFG_DATA_W-1:0] xs_reg;
    logic [arcb_pkg::CFG_DATA_W-1:0] ys_reg;
    logic [arcb_pkg::EPS_W-1:0]      eps_reg;

    arcb_pkg::vec_t anc_reg [3];
    arcb_pkg::vec_t cur_reg [9];
    arcb_pkg::vec_t prv_reg [9];
    arcb_pkg::vec_t mo_reg  [9];

    logic                            func_reg;
    logic [arcb_pkg::COORD_BITS-1:0] posx_reg;
    logic [arcb_pkg::COORD_BITS-1:0] posy_reg;
    logic signed [32:0]              px_reg;
    logic signed [32:0]              py_reg;
    logic [63:0]                     s_reg;
    logic                            outs_reg;
    logic [31:0]                     root_reg;
    arcb_pkg::vec_t                  e_reg [3];
    logic signed [32:0]              c_reg [3];
    logic signed [32:0]              dot_reg;
    arcb_pkg::vec_t                  q_reg [4];
    arcb_pkg::mul_t                  r_reg [9];
    logic [63:0]                     n_reg;
    logic signed [63:0]              num_reg;
    arcb_pkg::acc_t                  prod_reg;
    arcb_pkg::acc_t                  acc_reg;

    arcb_pkg::mul_t     mul_a;
    arcb_pkg::mul_t     mul_b;
    logic               acc_clr;
    logic               acc_sub;
    arcb_pkg::acc_t     acc_sum;
    arcb_pkg::acc_t     acc_shr;
    logic               mac_state;
    logic               mac_wb;
    logic               div_state;
    logic               dv_done;
    logic [32:0]        ax;
    logic [32:0]        ay;
    logic [1:0]         ca;
    logic [1:0]         cb;
    logic [1:0]         rn_a0;
    logic [1:0]         rn_b0;
    logic [1:0]         rn_a1;
    logic [1:0]         rn_b1;
    logic               rn_sub;
    logic               rn_diag;
    logic [3:0]         r_ix;
    logic [3:0]         p_ix;
    logic [3:0]         o_ix;
    logic [63:0]        nmag;
    logic [63:0]        len;
    logic               nz;
    logic               out_load;
    arcb_pkg::mul_t     rq;

    arcb_pkg::arcb_cmd_t            dv_cmd;
    arcb_pkg::arcb_stat_t           dv_stat;
    logic [arcb_pkg::DIV_NUM_W-1:0] dv_num;
    logic [arcb_pkg::DIV_DEN_W-1:0] dv_den;
    logic [arcb_pkg::DIV_DEN_W-1:0] dv_res;

    function automatic logic signed [32:0] sat_px(arcb_pkg::acc_t v);
        arcb_pkg::acc_t t;
        t = v;
        if (t > arcb_pkg::TWO_A)
            t = arcb_pkg::TWO_A;
        else if (t < -arcb_pkg::TWO_A)
            t = -arcb_pkg::TWO_A;
        return t[32:0];
    endfunction

    function automatic arcb_pkg::vec_t clamp1(logic signed [32:0] v);
        logic signed [32:0] one;
        logic signed [32:0] t;
        one = 33'(arcb_pkg::ONE_A);
        t   = v;
        if (t > one)
            t = one;
        else if (t < -one)
            t = -one;
        return t[31:0];
    endfunction

    function automatic arcb_pkg::vec_t sat32(arcb_pkg::acc_t v);
        arcb_pkg::acc_t t;
        t = v;
        if (t > arcb_pkg::I32_MAX)
            t = arcb_pkg::I32_MAX;
        else if (t < arcb_pkg::I32_MIN)
            t = arcb_pkg::I32_MIN;
        return t[31:0];
    endfunction

    assign ax = px_reg[32] ? 33'(-px_reg) : 33'(px_reg);
    assign ay = py_reg[32] ? 33'(-py_reg) : 33'(py_reg);

    assign r_ix = 4'({2'b00, row_reg} * 4'd3) + 4'(idx_reg[1:0]);
    assign p_ix = 4'({2'b00, idx_reg[1:0]} * 4'd3) + 4'(col_reg);
    assign o_ix = 4'({2'b00, row_reg} * 4'd3) + 4'(col_reg);

    // cross product operand pairs: (a[i+1], e[i+2]) minus (a[i+2], e[i+1])
    always_comb
    begin
        unique case (idx_reg)
            3'd0:    begin ca = 2'd1; cb = 2'd2; end
            3'd1:    begin ca = 2'd2; cb = 2'd1; end
            3'd2:    begin ca = 2'd2; cb = 2'd0; end
            3'd3:    begin ca = 2'd0; cb = 2'd2; end
            3'd4:    begin ca = 2'd0; cb = 2'd1; end
            3'd5:    begin ca = 2'd1; cb = 2'd0; end
            default: begin ca = 2'd0; cb = 2'd0; end
        endcase
    end

    // rotation matrix numerators, q index order x, y, z, w
    always_comb
    begin
        rn_diag = 1'b0;
        rn_sub  = 1'b0;
        unique case (el_reg)
            4'd0: begin rn_a0 = 2'd1; rn_b0 = 2'd1; rn_a1 = 2'd2; rn_b1 = 2'd2;
                        rn_diag = 1'b1; end
            4'd1: begin rn_a0 = 2'd0; rn_b0 = 2'd1; rn_a1 = 2'd2; rn_b1 = 2'd3;
                        rn_sub = 1'b1; end
            4'd2: begin rn_a0 = 2'd0; rn_b0 = 2'd2; rn_a1 = 2'd1; rn_b1 = 2'd3; end
            4'd3: begin rn_a0 = 2'd0; rn_b0 = 2'd1; rn_a1 = 2'd2; rn_b1 = 2'd3; end
            4'd4: begin rn_a0 = 2'd0; rn_b0 = 2'd0; rn_a1 = 2'd2; rn_b1 = 2'd2;
                        rn_diag = 1'b1; end
            4'd5: begin rn_a0 = 2'd1; rn_b0 = 2'd2; rn_a1 = 2'd0; rn_b1 = 2'd3;
                        rn_sub = 1'b1; end
            4'd6: begin rn_a0 = 2'd0; rn_b0 = 2'd2; rn_a1 = 2'd1; rn_b1 = 2'd3;
                        rn_sub = 1'b1; end
            4'd7: begin rn_a0 = 2'd1; rn_b0 = 2'd2; rn_a1 = 2'd0; rn_b1 = 2'd3; end
            4'd8: begin rn_a0 = 2'd0; rn_b0 = 2'd0; rn_a1 = 2'd1; rn_b1 = 2'd1;
                        rn_diag = 1'b1; end
            default: begin rn_a0 = 2'd0; rn_b0 = 2'd0; rn_a1 = 2'd0; rn_b1 = 2'd0; end
        endcase
    end

    // multiply-accumulate operand select
    always_comb
    begin
        mul_a   = '0;
        mul_b   = '0;
        acc_clr = 1'b0;
        acc_sub = 1'b0;
        unique case (state_reg)
            ST_MAP:
            begin
                acc_clr = 1'b1;
                if (idx_reg[0])
                begin
                    mul_a = arcb_pkg::mul_t'({1'b0, posy_reg});
                    mul_b = arcb_pkg::mul_t'({1'b0, ys_reg});
                end
                else
                begin
                    mul_a = arcb_pkg::mul_t'({1'b0, posx_reg});
                    mul_b = arcb_pkg::mul_t'({1'b0, xs_reg});
                end
            end
            ST_SQ:
            begin
                acc_clr = !idx_reg[0];
                mul_a   = arcb_pkg::mul_t'({1'b0, idx_reg[0] ? ay : ax});
                mul_b   = mul_a;
            end
            ST_CROSS:
            begin
                acc_clr = !idx_reg[0];
                acc_sub = idx_reg[0];
                mul_a   = arcb_pkg::mul_t'(anc_reg[ca]);
                mul_b   = arcb_pkg::mul_t'(e_reg[cb]);
            end
            ST_DOT:
            begin
                acc_clr = idx_reg == 3'd0;
                mul_a   = arcb_pkg::mul_t'(anc_reg[idx_reg[1:0]]);
                mul_b   = arcb_pkg::mul_t'(e_reg[idx_reg[1:0]]);
            end
            ST_LEN:
            begin
                acc_clr = idx_reg == 3'd0;
                mul_a   = arcb_pkg::mul_t'(c_reg[idx_reg[1:0]]);
                mul_b   = mul_a;
            end
            ST_NORM:
            begin
                acc_clr = idx_reg == 3'd0;
                mul_a   = arcb_pkg::mul_t'(q_reg[idx_reg[1:0]]);
                mul_b   = mul_a;
            end
            ST_RNUM:
            begin
                acc_clr = !idx_reg[0];
                acc_sub = idx_reg[0] && rn_sub;
                mul_a   = arcb_pkg::mul_t'(q_reg[idx_reg[0] ? rn_a1 : rn_a0]);
                mul_b   = arcb_pkg::mul_t'(q_reg[idx_reg[0] ? rn_b1 : rn_b0]);
            end
            ST_PROD:
            begin
                acc_clr = idx_reg == 3'd0;
                mul_a   = r_reg[r_ix];
                mul_b   = arcb_pkg::mul_t'(prv_reg[p_ix]);
            end
            default:
            begin
                mul_a = '0;
            end
        endcase
    end

    assign acc_sum = (acc_clr ? arcb_pkg::acc_t'(0) : acc_reg)
                   + (acc_sub ? -prod_reg : prod_reg);
    assign acc_shr = acc_sum >>> arcb_pkg::FRAC_BITS;

    assign mac_state = (state_reg == ST_MAP) || (state_reg == ST_SQ)
                    || (state_reg == ST_CROSS) || (state_reg == ST_DOT)
                    || (state_reg == ST_LEN) || (state_reg == ST_NORM)
                    || (state_reg == ST_RNUM) || (state_reg == ST_PROD);
    assign mac_wb    = mac_state && ph_reg;
    assign div_state = (state_reg == ST_ROOT) || (state_reg == ST_NRM)
                    || (state_reg == ST_RDIV);
    assign dv_done   = div_state && ph_reg && dv_stat.done;

    assign len = acc_sum[63:0];
    assign nz  = len > 64'({eps_reg, {arcb_pkg::FRAC_BITS{1'b0}}});
    assign nmag = num_reg[63] ? 64'(-num_reg) : 64'(num_reg);
    assign rq   = arcb_pkg::mul_t'({1'b0, dv_res[32:0]});

    // divide/sqrt operands
    always_comb
    begin
        dv_cmd.start     = div_state && !ph_reg;
        dv_cmd.sqrt_mode = state_reg == ST_ROOT;
        dv_num           = '0;
        dv_den           = '0;
        unique case (state_reg)
            ST_ROOT:
            begin
                dv_num = arcb_pkg::DIV_NUM_W'(outs_reg ? s_reg : arcb_pkg::UNIT2 - s_reg);
            end
            ST_NRM:
            begin
                dv_num = arcb_pkg::DIV_NUM_W'({idx_reg[0] ? ay : ax,
                                               {arcb_pkg::FRAC_BITS{1'b0}}});
                dv_den = arcb_pkg::DIV_DEN_W'(root_reg);
            end
            ST_RDIV:
            begin
                dv_num = arcb_pkg::DIV_NUM_W'({nmag, {(arcb_pkg::FRAC_BITS + 1){1'b0}}});
                dv_den = n_reg;
            end
            default:
            begin
                dv_den = '0;
            end
        endcase
    end

    arcb_divsqrt u_divsqrt (
        .clk  (clk),
        .rst_n(rst_n),
        .cmd  (dv_cmd),
        .num  (dv_num),
        .den  (dv_den),
        .stat (dv_stat),
        .res  (dv_res)
    );

    assign out_load = (state_reg == ST_OUT) && (!ov_reg || mat.ready);

    // sequencer, configuration and architectural state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            ph_reg    <= 1'b0;
            idx_reg   <= '0;
            el_reg    <= '0;
            row_reg   <= '0;
            col_reg   <= '0;
            ov_reg    <= 1'b0;
            xs_reg    <= arcb_pkg::SCALE_RESET;
            ys_reg    <= arcb_pkg::SCALE_RESET;
            eps_reg   <= arcb_pkg::EPS_RESET;
            for (int i = 0; i < 3; i++)
                anc_reg[i] <= '0;
            for (int i = 0; i < 9; i++)
            begin
                cur_reg[i] <= (i % 4 == 0) ? arcb_pkg::ONE_A[31:0] : '0;
                prv_reg[i] <= (i % 4 == 0) ? arcb_pkg::ONE_A[31:0] : '0;
            end
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    arcb_pkg::CFG_X_SCALE: xs_reg  <= cfg_data;
                    arcb_pkg::CFG_Y_SCALE: ys_reg  <= cfg_data;
                    arcb_pkg::CFG_EPS:     eps_reg <= cfg_data[arcb_pkg::EPS_W-1:0];
                    default:               eps_reg <= eps_reg;
                endcase
            end

            if (out_load)
                ov_reg <= 1'b1;
            else if (mat.ready)
                ov_reg <= 1'b0;

            if (mac_state)
                ph_reg <= !ph_reg;
            else if (div_state && !ph_reg)
                ph_reg <= 1'b1;
            else if (dv_done)
                ph_reg <= 1'b0;

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (evt.valid)
                    begin
                        state_reg <= ST_MAP;
                        idx_reg   <= '0;
                        ph_reg    <= 1'b0;
                    end
                end
                ST_MAP:
                begin
                    if (mac_wb)
                    begin
                        idx_reg <= idx_reg[0] ? 3'd0 : 3'd1;
                        if (idx_reg[0])
                            state_reg <= ST_SQ;
                    end
                end
                ST_SQ:
                begin
                    if (mac_wb)
                    begin
                        idx_reg <= idx_reg[0] ? 3'd0 : 3'd1;
                        if (idx_reg[0])
                            state_reg <= ST_ROOT;
                    end
                end
                ST_ROOT:
                begin
                    if (dv_done)
                    begin
                        idx_reg   <= '0;
                        state_reg <= outs_reg ? ST_NRM : ST_SPH;
                    end
                end
                ST_NRM:
                begin
                    if (dv_done)
                    begin
                        idx_reg <= idx_reg[0] ? 3'd0 : 3'd1;
                        if (idx_reg[0])
                            state_reg <= ST_SPH;
                    end
                end
                ST_SPH:
                begin
                    if (func_reg)
                    begin
                        state_reg <= ST_CROSS;
                    end
                    else
                    begin
                        for (int i = 0; i < 3; i++)
                            anc_reg[i] <= e_reg[i];
                        for (int i = 0; i < 9; i++)
                            prv_reg[i] <= cur_reg[i];
                        state_reg <= ST_OUT;
                    end
                    idx_reg <= '0;
                    ph_reg  <= 1'b0;
                end
                ST_CROSS:
                begin
                    if (mac_wb)
                    begin
                        idx_reg <= (idx_reg == 3'd5) ? 3'd0 : idx_reg + 3'd1;
                        if (idx_reg == 3'd5)
                            state_reg <= ST_DOT;
                    end
                end
                ST_DOT:
                begin
                    if (mac_wb)
                    begin
                        idx_reg <= (idx_reg == 3'd2) ? 3'd0 : idx_reg + 3'd1;
                        if (idx_reg == 3'd2)
                            state_reg <= ST_LEN;
                    end
                end
                ST_LEN:
                begin
                    if (mac_wb)
                    begin
                        idx_reg <= (idx_reg == 3'd2) ? 3'd0 : idx_reg + 3'd1;
                        if (idx_reg == 3'd2)
                            state_reg <= ST_NORM;
                    end
                end
                ST_NORM:
                begin
                    if (mac_wb)
                    begin
                        idx_reg <= (idx_reg == 3'd3) ? 3'd0 : idx_reg + 3'd1;
                        if (idx_reg == 3'd3)
                        begin
                            el_reg    <= '0;
                            row_reg   <= '0;
                            col_reg   <= '0;
                            state_reg <= (acc_sum == '0) ? ST_PROD : ST_RNUM;
                        end
                    end
                end
                ST_RNUM:
                begin
                    if (mac_wb)
                    begin
                        idx_reg <= idx_reg[0] ? 3'd0 : 3'd1;
                        if (idx_reg[0])
                            state_reg <= ST_RDIV;
                    end
                end
                ST_RDIV:
                begin
                    if (dv_done)
                    begin
                        if (el_reg == 4'd8)
                        begin
                            state_reg <= ST_PROD;
                        end
                        else
                        begin
                            el_reg    <= el_reg + 4'd1;
                            state_reg <= ST_RNUM;
                        end
                    end
                end
                ST_PROD:
                begin
                    if (mac_wb)
                    begin
                        idx_reg <= (idx_reg == 3'd2) ? 3'd0 : idx_reg + 3'd1;
                        if (idx_reg == 3'd2)
                        begin
                            cur_reg[o_ix] <= sat32(acc_shr);
                            col_reg <= (col_reg == 2'd2) ? 2'd0 : col_reg + 2'd1;
                            if (col_reg == 2'd2)
                            begin
                                row_reg <= row_reg + 2'd1;
                                if (row_reg == 2'd2)
                                    state_reg <= ST_OUT;
                            end
                        end
                    end
                end
                ST_OUT:
                begin
                    if (out_load)
                        state_reg <= ST_IDLE;
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (mac_state && !ph_reg)
            prod_reg <= mul_a * mul_b;
        if (mac_wb)
            acc_reg <= acc_sum;

        if (out_load)
            for (int i = 0; i < 9; i++)
                mo_reg[i] <= cur_reg[i];

        if (state_reg == ST_IDLE && evt.valid)
        begin
            func_reg <= evt.func;
            posx_reg <= evt.pos_x;
            posy_reg <= evt.pos_y;
        end

        if (mac_wb)
        begin
            unique case (state_reg)
                ST_MAP:
                begin
                    if (idx_reg[0])
                        py_reg <= sat_px(arcb_pkg::ONE_A - acc_sum);
                    else
                        px_reg <= sat_px(acc_sum - arcb_pkg::ONE_A);
                end
                ST_SQ:
                begin
                    if (idx_reg[0])
                    begin
                        s_reg    <= acc_sum[63:0];
                        outs_reg <= acc_sum[63:0] > arcb_pkg::UNIT2;
                    end
                end
                ST_CROSS:
                begin
                    if (idx_reg[0])
                        c_reg[idx_reg[2:1]] <= acc_shr[32:0];
                end
                ST_DOT:
                begin
                    if (idx_reg == 3'd2)
                        dot_reg <= acc_shr[32:0];
                end
                ST_LEN:
                begin
                    if (idx_reg == 3'd2)
                    begin
                        for (int i = 0; i < 3; i++)
                            q_reg[i] <= nz ? clamp1(c_reg[i]) : '0;
                        q_reg[3] <= nz ? clamp1(dot_reg) : '0;
                    end
                end
                ST_NORM:
                begin
                    if (idx_reg == 3'd3)
                    begin
                        n_reg <= acc_sum[63:0];
                        // zero quaternion: identity rotation
                        if (acc_sum == '0)
                            for (int i = 0; i < 9; i++)
                                r_reg[i] <= (i % 4 == 0) ? arcb_pkg::mul_t'(arcb_pkg::ONE_A)
                                                         : '0;
                    end
                end
                ST_RNUM:
                begin
                    if (idx_reg[0])
                        num_reg <= acc_sum[63:0];
                end
                default: ;
            endcase
        end

        if (dv_done)
        begin
            unique case (state_reg)
                ST_ROOT:
                begin
                    root_reg <= dv_res[31:0];
                    if (!outs_reg)
                    begin
                        e_reg[0] <= px_reg[31:0];
                        e_reg[1] <= py_reg[31:0];
                        e_reg[2] <= dv_res[31:0];
                    end
                end
                ST_NRM:
                begin
                    if (idx_reg[0])
                    begin
                        e_reg[1] <= py_reg[32] ? -arcb_pkg::vec_t'(dv_res[31:0])
                                               : arcb_pkg::vec_t'(dv_res[31:0]);
                        e_reg[2] <= '0;
                    end
                    else
                    begin
                        e_reg[0] <= px_reg[32] ? -arcb_pkg::vec_t'(dv_res[31:0])
                                               : arcb_pkg::vec_t'(dv_res[31:0]);
                    end
                end
                ST_RDIV:
                begin
                    if (rn_diag)
                        r_reg[el_reg] <= arcb_pkg::mul_t'(arcb_pkg::ONE_A) - rq;
                    else
                        r_reg[el_reg] <= num_reg[63] ? -rq : rq;
                end
                default:
                begin
                    root_reg <= root_reg;
                end
            endcase
        end
    end

    assign evt.ready = state_reg == ST_IDLE;
    assign mat.valid = ov_reg;
    assign mat.m00   = mo_reg[0];
    assign mat.m01   = mo_reg[1];
    assign mat.m02   = mo_reg[2];
    assign mat.m10   = mo_reg[3];
    assign mat.m11   = mo_reg[4];
    assign mat.m12   = mo_reg[5];
    assign mat.m20   = mo_reg[6];
    assign mat.m21   = mo_reg[7];
    assign mat.m22   = mo_reg[8];

    a_rdiv_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_RDIV |-> n_reg != '0)
        else $error("matrix divide by zero norm");

    a_root_floor: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_NRM |-> root_reg >= 32'(arcb_pkg::ONE_A))
        else $error("normalize with root below one");

    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        evt.valid && evt.ready |=> state_reg == ST_MAP)
        else $error("accepted event did not start the sequencer");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_OUT && ov_reg && !mat.ready |=> state_reg == ST_OUT)
        else $error("result dropped while output beat pending");

endmodule
